FILE: rtl/core/suh_pkg.sv
// Shared types and constants for the sample unpacker with histogram.
// Used by suh_front, suh_queue, suh_back and sample_unpack_histogram.
package suh_pkg;

  localparam int BIN_BITS = 16;
  localparam int NUM_BINS = 1 << BIN_BITS;
  localparam int COUNT_BITS = 32;
  localparam int RESULT_COUNT_BITS = 32;
  localparam int VALUE_BITS = BIN_BITS + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [BIN_BITS-1:0] SIGN_FLIP = {1'b1, {(BIN_BITS-1){1'b0}}};

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic                mode;
    logic [BIN_BITS-1:0] word;
  } sample_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]   unpacked_value;
    logic [RESULT_COUNT_BITS-1:0]   bin_count;
    logic                           is_count;
  } result_t;

  typedef struct packed {
    logic                         is_read;
    logic [BIN_BITS-1:0]          bin;
    logic signed [VALUE_BITS-1:0] value;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } qhead_t;

  function automatic logic [RESULT_COUNT_BITS-1:0] clamp_count(input count_t c);
    logic [63:0] wide;
    wide = 64'(c);
    if (wide > 64'({RESULT_COUNT_BITS{1'b1}})) begin
      return '1;
    end
    return wide[RESULT_COUNT_BITS-1:0];
  endfunction

endpackage

FILE: rtl/core/suh_front.sv
// Front end: holds the offset_binary register, accepts words and turns each
// into a histogram op (bin index and unpacked value). Depends on suh_pkg.
module suh_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic            cfg_data,
  input  logic            sample_valid,
  output logic            sample_stall,
  input  suh_pkg::sample_t sample,
  input  logic            queue_full,
  output logic            push,
  output suh_pkg::op_t    push_op
);

  logic offset_binary;
  logic [suh_pkg::BIN_BITS-1:0] raw;
  logic [suh_pkg::BIN_BITS-1:0] bin;
  logic signed [suh_pkg::BIN_BITS-1:0] v;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_binary <= 1'b0;
    end else if (cfg_valid) begin
      offset_binary <= cfg_data;
    end
  end

  always_comb begin
    raw = sample.word ^ (offset_binary ? suh_pkg::SIGN_FLIP : '0);
    bin = raw ^ suh_pkg::SIGN_FLIP;
    v = signed'(raw);
    push_op.is_read = (sample.mode == suh_pkg::MODE_READ);
    push_op.bin = push_op.is_read ? sample.word : bin;
    push_op.value = push_op.is_read ? '0 : signed'({v, 1'b1});
  end

  assign sample_stall = queue_full;
  assign push = sample_valid && !queue_full;

endmodule

FILE: rtl/core/suh_queue.sv
// Short op queue between front and back end.
// Depends on suh_pkg for op_t and queue sizing.
module suh_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  suh_pkg::op_t    push_op,
  output logic            full,
  input  logic            pop,
  output suh_pkg::qhead_t head
);

  suh_pkg::op_t entries [suh_pkg::QUEUE_DEPTH];
  logic [suh_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [suh_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [suh_pkg::QCNT_BITS-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign full = (count == suh_pkg::QCNT_BITS'(suh_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.op = entries[rd_ptr];

endmodule

FILE: rtl/core/suh_back.sv
// Back end: clears the histogram memory after reset, then runs the
// read-modify-write of each sample op with forwarding, reads the count for
// each read op and drives the result register. Depends on suh_pkg.
module suh_back (
  input  logic             clk,
  input  logic             rst,
  input  suh_pkg::qhead_t  head,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output suh_pkg::result_t result
);

  suh_pkg::count_t mem [suh_pkg::NUM_BINS];

  logic clearing;
  logic [suh_pkg::BIN_BITS-1:0] clr_addr;

  logic s1_valid;
  suh_pkg::op_t s1_op;
  suh_pkg::count_t rd_data;

  logic last_valid;
  logic [suh_pkg::BIN_BITS-1:0] last_addr;
  suh_pkg::count_t last_data;

  suh_pkg::count_t cur_count;
  suh_pkg::count_t count_next;
  logic s1_adv;
  logic mem_we;
  logic [suh_pkg::BIN_BITS-1:0] mem_waddr;
  suh_pkg::count_t mem_wdata;

  always_comb begin
    cur_count = (last_valid && last_addr == s1_op.bin) ? last_data : rd_data;
    count_next = (cur_count == '1) ? cur_count : cur_count + 1'b1;
    s1_adv = s1_valid && (!result_valid || !result_stall);
    pop = head.valid && !clearing && (!s1_valid || s1_adv);
    mem_we = clearing || (s1_adv && !s1_op.is_read);
    mem_waddr = clearing ? clr_addr : s1_op.bin;
    mem_wdata = clearing ? '0 : count_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data <= mem[head.op.bin];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      s1_valid <= 1'b0;
      last_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == '1) begin
          clearing <= 1'b0;
        end
      end
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv && !s1_op.is_read) begin
        last_valid <= 1'b1;
      end
      if (s1_adv) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op <= head.op;
    end
    if (s1_adv && !s1_op.is_read) begin
      last_addr <= s1_op.bin;
      last_data <= count_next;
    end
    if (s1_adv) begin
      result.unpacked_value <= s1_op.is_read ? '0 : s1_op.value;
      result.bin_count <= s1_op.is_read ? suh_pkg::clamp_count(cur_count) : '0;
      result.is_count <= s1_op.is_read;
    end
  end

endmodule

FILE: rtl/core/sample_unpack_histogram.sv
// Top level of the 16-bit sample unpacker with occupancy histogram.
// Instantiates suh_front, suh_queue and suh_back; depends on suh_pkg.
//
//   channel  | handshake              | word
//   ---------+------------------------+-------------------------------------
//   sample   | sample_valid/_stall    | suh_pkg::sample_t (mode, word)
//   result   | result_valid/_stall    | suh_pkg::result_t (value, count, flag)
//   cfg      | cfg_valid/cfg_ready    | cfg_data = offset_binary
//
// One word per cycle sustained while neither the clear nor result_stall holds
// the flow; each accepted word passes the queue entry, the memory read stage
// and the result register. Every word gives one result.
// After reset the back end clears the 65536-entry histogram memory, one entry
// a cycle; words queue up meanwhile and sample_stall rises once the four-entry
// queue fills. result_stall holds the result register and backs up through
// the memory stage into the queue.
module sample_unpack_histogram (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  suh_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output suh_pkg::result_t result
);

  logic            push;
  suh_pkg::op_t    push_op;
  logic            queue_full;
  logic            pop;
  suh_pkg::qhead_t head;

  assign cfg_ready = 1'b1;

  suh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .queue_full   (queue_full),
    .push         (push),
    .push_op      (push_op)
  );

  suh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (queue_full),
    .pop     (pop),
    .head    (head)
  );

  suh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
